// File: src/sprite_xor_draw_engine_top_defines.svh
// assertion macros shared by the sprite draw engine modules
`ifndef SPRITE_XOR_DRAW_ENGINE_TOP_DEFINES_SVH
`define SPRITE_XOR_DRAW_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SXD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sprite draw engine check failed");

// next-cycle implication, disabled while reset is asserted
`define SXD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sprite draw engine check failed");

`endif

// File: src/sxd_pkg.sv
// types and constants of the sprite xor draw engine
package sxd_pkg;

	localparam int ROW_PIXELS_DEF  = 64;
	localparam int ROW_COUNT_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int ACTION_W   = 2;
	localparam int COORD_W    = 8;
	localparam int IDX_W      = 4;
	localparam int SPRITE_W   = 8;
	localparam int READ_ROW_W = 5;
	localparam int PIX_W      = 64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	// classification handed from front to back
	typedef struct packed {
		action_t act;
		logic    hit_clr;
		logic    hit_row;
		logic    last_row;
	} sxd_ctl_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

// File: src/sxd_in_if.sv
// input channel: draw, clear and read items
interface sxd_in_if;
	logic                              valid;
	logic                              ready;
	logic [sxd_pkg::ACTION_W-1:0]      action;
	logic [sxd_pkg::COORD_W-1:0]       x_coord;
	logic [sxd_pkg::COORD_W-1:0]       y_coord;
	logic [sxd_pkg::IDX_W-1:0]         row_index;
	logic [sxd_pkg::SPRITE_W-1:0]      row_byte;
	logic                              last_row;
	logic [sxd_pkg::READ_ROW_W-1:0]    read_row;

	modport source (
		output valid, action, x_coord, y_coord, row_index, row_byte, last_row, read_row,
		input  ready
	);
	modport sink (
		input  valid, action, x_coord, y_coord, row_index, row_byte, last_row, read_row,
		output ready
	);
endinterface

// File: src/sxd_out_if.sv
// output channel: one result item per input item
interface sxd_out_if;
	logic                         valid;
	logic                         ready;
	logic                         collision;
	logic                         done_res;
	logic [sxd_pkg::PIX_W-1:0]    row_pixels;

	modport source (
		output valid, collision, done_res, row_pixels,
		input  ready
	);
	modport sink (
		input  valid, collision, done_res, row_pixels,
		output ready
	);
endinterface

// File: src/sprite_xor_draw_engine_top.sv
// top level of the sprite xor draw engine
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | action, x_coord, y_coord, row_index, row_byte, last_row,
//          |     |               | read_row
//  res     | out | valid / ready | collision, done_res, row_pixels
//
// in the back end BK_IDLE pops an item and does the registered frame store read, and BK_EXEC
// does the xor write-back and the load of the result register
// the front classifies an item in its accept cycle and the queue holds QUEUE_DEPTH items
// reset clears the row valid bits at once, so the store reads blank with no clearing pass
// a clear item drops all row valid bits in its write-back cycle
// a result waiting in the output register stalls the back end; the front keeps filling the queue
module sprite_xor_draw_engine_top #(
	parameter int ROW_PIXELS  = sxd_pkg::ROW_PIXELS_DEF,
	parameter int ROW_COUNT   = sxd_pkg::ROW_COUNT_DEF,
	parameter int QUEUE_DEPTH = sxd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sxd_in_if.sink       cmd,
	sxd_out_if.source    res
);

	localparam int RW = $clog2(ROW_COUNT);
	localparam int QW = $bits(sxd_pkg::sxd_ctl_t) + RW + ROW_PIXELS;

	sxd_pkg::sxd_ctl_t      f_ctl;
	logic [RW-1:0]          f_addr;
	logic [ROW_PIXELS-1:0]  f_mask;
	sxd_pkg::sxd_ctl_t      b_ctl;
	logic [RW-1:0]          b_addr;
	logic [ROW_PIXELS-1:0]  b_mask;

	logic           push;
	logic           full;
	logic           pop;
	logic           q_valid;
	logic [QW-1:0]  q_din;
	logic [QW-1:0]  q_dout;

	sxd_front #(
		.ROW_PIXELS (ROW_PIXELS),
		.ROW_COUNT  (ROW_COUNT)
	) u_front (
		.cmd  (cmd),
		.full (full),
		.push (push),
		.ctl  (f_ctl),
		.addr (f_addr),
		.mask (f_mask)
	);

	assign q_din = {f_ctl, f_addr, f_mask};

	sxd_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (q_din),
		.full     (full),
		.pop      (pop),
		.dout     (q_dout),
		.nonempty (q_valid)
	);

	assign {b_ctl, b_addr, b_mask} = q_dout;

	sxd_back #(
		.ROW_PIXELS (ROW_PIXELS),
		.ROW_COUNT  (ROW_COUNT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.pop     (pop),
		.ctl     (b_ctl),
		.addr    (b_addr),
		.mask    (b_mask),
		.res     (res)
	);

endmodule

// File: src/sxd_front.sv
// front end: accepts items, wraps coordinates and builds the row mask
module sxd_front #(
	parameter int ROW_PIXELS = sxd_pkg::ROW_PIXELS_DEF,
	parameter int ROW_COUNT  = sxd_pkg::ROW_COUNT_DEF,
	localparam int RW = $clog2(ROW_COUNT)
) (
	sxd_in_if.sink                  cmd,
	input  logic                    full,
	output logic                    push,
	output sxd_pkg::sxd_ctl_t       ctl,
	output logic [RW-1:0]           addr,
	output logic [ROW_PIXELS-1:0]   mask
);

	localparam int CW      = $clog2(ROW_PIXELS);
	localparam int SW      = $clog2(ROW_COUNT + 16);
	localparam int COORD_N = 1 << sxd_pkg::COORD_W;
	localparam int SPW     = ROW_PIXELS + sxd_pkg::SPRITE_W;

	logic [CW-1:0]  col_tbl  [COORD_N];
	logic [RW-1:0]  rowb_tbl [COORD_N];

	// modulo tables, worked out at elaboration
	for (genvar i = 0; i < COORD_N; i++) begin : g_tbl
		localparam logic [CW-1:0] COL  = CW'(i % ROW_PIXELS);
		localparam logic [RW-1:0] ROWB = RW'(i % ROW_COUNT);
		assign col_tbl[i]  = COL;
		assign rowb_tbl[i] = ROWB;
	end

	logic [CW-1:0]   col0;
	logic [SW-1:0]   row_sum;
	logic            row_ok;
	logic            rd_ok;
	logic [SPW-1:0]  spread;
	sxd_pkg::action_t act;

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;
	assign act       = sxd_pkg::action_t'(cmd.action);

	assign col0    = col_tbl[cmd.x_coord];
	assign row_sum = SW'(rowb_tbl[cmd.y_coord]) + SW'(cmd.row_index);
	assign row_ok  = row_sum < SW'(ROW_COUNT);
	assign rd_ok   = 32'(cmd.read_row) < ROW_COUNT;

	// bits shifted past the right edge drop out of the kept window
	assign spread = {cmd.row_byte, {ROW_PIXELS{1'b0}}} >> col0;
	assign mask   = spread[SPW-1:sxd_pkg::SPRITE_W];

	always_comb begin
		ctl.act      = act;
		ctl.hit_clr  = 1'b0;
		ctl.hit_row  = 1'b0;
		ctl.last_row = 1'b0;
		addr         = '0;
		case (act)
			sxd_pkg::ACT_DRAW: begin
				ctl.hit_clr  = (cmd.row_index == '0);
				ctl.hit_row  = row_ok;
				ctl.last_row = cmd.last_row;
				addr         = RW'(row_sum);
			end
			sxd_pkg::ACT_READ: begin
				ctl.hit_row = rd_ok;
				addr        = RW'(cmd.read_row);
			end
			default: begin
				ctl.hit_row = 1'b0;
			end
		endcase
	end

endmodule

// File: src/sxd_queue.sv
// short queue between front and back
`include "sprite_xor_draw_engine_top_defines.svh"

module sxd_queue #(
	parameter int W     = 8,
	parameter int DEPTH = sxd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  din,
	output logic          full,
	input  logic          pop,
	output logic [W-1:0]  dout,
	output logic          nonempty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]      mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign dout     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	`SXD_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, (count_q != '0))
	`SXD_ASSERT_IMP(a_no_push_full, clk, arst_n, push, (count_q != CNT_W'(DEPTH)))
	`SXD_ASSERT_NXT(a_cnt_up, clk, arst_n, (push && !pop), (count_q == CNT_W'($past(count_q) + 1'b1)))

endmodule

// File: src/sxd_back.sv
// back end: frame store read-modify-write, collision flag and result register
`include "sprite_xor_draw_engine_top_defines.svh"

module sxd_back #(
	parameter int ROW_PIXELS = sxd_pkg::ROW_PIXELS_DEF,
	parameter int ROW_COUNT  = sxd_pkg::ROW_COUNT_DEF,
	localparam int RW = $clog2(ROW_COUNT)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    pop,
	input  sxd_pkg::sxd_ctl_t       ctl,
	input  logic [RW-1:0]           addr,
	input  logic [ROW_PIXELS-1:0]   mask,
	sxd_out_if.source               res
);

	localparam int ROWS_PHYS = 1 << RW;
	localparam int PIX_SH    = sxd_pkg::PIX_W - ROW_PIXELS;

	sxd_pkg::bk_state_t  state_q;
	sxd_pkg::bk_state_t  state_d;
	logic                fire;

	sxd_pkg::sxd_ctl_t      op_ctl_q;
	logic [RW-1:0]          op_addr_q;
	logic [ROW_PIXELS-1:0]  op_mask_q;

	logic [ROW_PIXELS-1:0]  store_q [ROWS_PHYS];
	logic [ROWS_PHYS-1:0]   row_vld_q;
	logic [ROW_PIXELS-1:0]  rd_data_q;
	logic                   rd_vld_q;
	logic                   hit_q;

	logic                         out_vld_q;
	logic                         out_coll_q;
	logic                         out_done_q;
	logic [sxd_pkg::PIX_W-1:0]    out_pix_q;

	logic [ROW_PIXELS-1:0]      old_row;
	logic                       hit_base;
	logic                       hit_nx;
	logic                       wr_en;
	logic [sxd_pkg::PIX_W-1:0]  pix_nx;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sxd_pkg::BK_IDLE: begin
				if (q_valid) state_d = sxd_pkg::BK_EXEC;
			end
			sxd_pkg::BK_EXEC: begin
				if (fire) state_d = sxd_pkg::BK_IDLE;
			end
			default: begin
				state_d = sxd_pkg::BK_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop  = 1'b0;
		fire = 1'b0;
		case (state_q)
			sxd_pkg::BK_IDLE: begin
				pop = q_valid;
			end
			sxd_pkg::BK_EXEC: begin
				fire = !out_vld_q || res.ready;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// rows not written since the last clear read as blank
	assign old_row  = rd_vld_q ? rd_data_q : '0;
	assign hit_base = op_ctl_q.hit_clr ? 1'b0 : hit_q;

	always_comb begin
		hit_nx = hit_q;
		wr_en  = 1'b0;
		pix_nx = '0;
		case (op_ctl_q.act)
			sxd_pkg::ACT_DRAW: begin
				hit_nx = hit_base | (op_ctl_q.hit_row & (|(old_row & op_mask_q)));
				wr_en  = fire && op_ctl_q.hit_row;
			end
			sxd_pkg::ACT_READ: begin
				if (op_ctl_q.hit_row) pix_nx = sxd_pkg::PIX_W'(old_row) << PIX_SH;
			end
			default: begin
				hit_nx = hit_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sxd_pkg::BK_IDLE;
			row_vld_q <= '0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire && op_ctl_q.act == sxd_pkg::ACT_CLEAR) begin
				row_vld_q <= '0;
			end else if (wr_en) begin
				row_vld_q[op_addr_q] <= 1'b1;
			end
			if (fire) begin
				hit_q     <= hit_nx;
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// frame store, operand and result registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[op_addr_q] <= old_row ^ op_mask_q;
		end
		if (pop) begin
			rd_data_q <= store_q[addr];
			rd_vld_q  <= row_vld_q[addr];
			op_ctl_q  <= ctl;
			op_addr_q <= addr;
			op_mask_q <= mask;
		end
		if (fire) begin
			out_coll_q <= hit_nx;
			out_done_q <= op_ctl_q.last_row;
			out_pix_q  <= pix_nx;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.collision  = out_coll_q;
	assign res.done_res   = out_done_q;
	assign res.row_pixels = out_pix_q;

	`SXD_ASSERT_NXT(a_exec_holds, clk, arst_n, (state_q == sxd_pkg::BK_EXEC && !fire), (state_q == sxd_pkg::BK_EXEC))
	`SXD_ASSERT_NXT(a_clear_wipes, clk, arst_n, (fire && op_ctl_q.act == sxd_pkg::ACT_CLEAR), (row_vld_q == '0))
	`SXD_ASSERT_NXT(a_read_off_end, clk, arst_n, (fire && op_ctl_q.act == sxd_pkg::ACT_READ && !op_ctl_q.hit_row), (out_pix_q == '0 && out_vld_q))

endmodule

// File: tb/sv/tb_top.sv
// testbench for the sprite xor draw engine: random and directed items checked against a predictor
`timescale 1ns / 1ps

import sxd_pkg::*;

typedef struct packed {
	action_t                   act;
	logic [COORD_W-1:0]        x_coord;
	logic [COORD_W-1:0]        y_coord;
	logic [IDX_W-1:0]          row_index;
	logic [SPRITE_W-1:0]       row_byte;
	logic                      last_row;
	logic [READ_ROW_W-1:0]     read_row;
} sprite_cmd_t;

typedef struct packed {
	logic                      collision;
	logic                      done_res;
	logic [PIX_W-1:0]          row_pixels;
} draw_result_t;

class frame_scoreboard;
	localparam int NCOLS = ROW_PIXELS_DEF;
	localparam int NROWS = ROW_COUNT_DEF;

	logic [PIX_W-1:0] shadow_fb [NROWS];
	logic             hit;
	draw_result_t     owed_q[$];
	int               errors;

	function new();
		foreach (shadow_fb[i]) shadow_fb[i] = '0;
		hit = 1'b0;
		errors = 0;
	endfunction

	// xor one sprite row into the shadow frame, or clear / read it
	function draw_result_t predict_result(sprite_cmd_t c);
		draw_result_t r;
		int col0;
		int row;
		int col;
		int k;
		logic [PIX_W-1:0] word;
		r = '0;
		case (c.act)
			ACT_DRAW: begin
				col0 = int'(c.x_coord) % NCOLS;
				row = int'(c.y_coord) % NROWS + int'(c.row_index);
				if (c.row_index == 0)
					hit = 1'b0;
				if (row < NROWS) begin
					word = shadow_fb[row];
					for (k = 0; k < 8; k++) begin
						col = col0 + k;
						if (col >= NCOLS)
							break;
						if (c.row_byte[7-k]) begin
							if (word[63-col])
								hit = 1'b1;
							word[63-col] = ~word[63-col];
						end
					end
					shadow_fb[row] = word;
				end
				r.done_res = c.last_row;
			end
			ACT_CLEAR: begin
				foreach (shadow_fb[i]) shadow_fb[i] = '0;
			end
			ACT_READ: begin
				if (int'(c.read_row) < NROWS)
					r.row_pixels = shadow_fb[c.read_row];
			end
			default: ;
		endcase
		r.collision = hit;
		return r;
	endfunction

	function void note_cmd(sprite_cmd_t c);
		owed_q.push_back(predict_result(c));
	endfunction

	function int owed();
		return owed_q.size();
	endfunction

	function void check_res(logic col, logic done, logic [PIX_W-1:0] pix);
		draw_result_t e;
		if (owed_q.size() == 0) begin
			$error("result item arrived with none expected");
			errors++;
			return;
		end
		e = owed_q.pop_front();
		if (col !== e.collision) begin
			$error("collision mismatch: expected %0b, got %0b", e.collision, col);
			errors++;
		end
		if (done !== e.done_res) begin
			$error("done_res mismatch: expected %0b, got %0b", e.done_res, done);
			errors++;
		end
		if (pix !== e.row_pixels) begin
			$error("row_pixels mismatch: expected %h, got %h", e.row_pixels, pix);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int N_ITEMS        = 1450;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;

	sxd_in_if  cmd_if ();
	sxd_out_if res_if ();

	sprite_xor_draw_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	frame_scoreboard sb;

	bit src_slow = 1'b1;
	bit snk_slow = 1'b1;
	int n_sent, n_results, n_draws, n_reads, n_clears, n_nops, n_done, n_collide;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// counts cycles in which no item moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic sprite_cmd_t mk_cmd(action_t a, int x, int y, int idx, int bits,
		int last, int rrow);
		sprite_cmd_t c;
		c.act       = a;
		c.x_coord   = x[COORD_W-1:0];
		c.y_coord   = y[COORD_W-1:0];
		c.row_index = idx[IDX_W-1:0];
		c.row_byte  = bits[SPRITE_W-1:0];
		c.last_row  = last[0];
		c.read_row  = rrow[READ_ROW_W-1:0];
		return c;
	endfunction

	function automatic sprite_cmd_t rand_cmd(action_t a);
		return mk_cmd(a, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 15),
			$urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 31));
	endfunction

	task automatic send_cmd(sprite_cmd_t c);
		int gap;
		gap = src_slow ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.action    <= c.act;
		cmd_if.x_coord   <= c.x_coord;
		cmd_if.y_coord   <= c.y_coord;
		cmd_if.row_index <= c.row_index;
		cmd_if.row_byte  <= c.row_byte;
		cmd_if.last_row  <= c.last_row;
		cmd_if.read_row  <= c.read_row;
		do @(posedge clk); while (!cmd_if.ready);
		sb.note_cmd(c);
		n_sent++;
		case (c.act)
			ACT_DRAW:  n_draws++;
			ACT_CLEAR: n_clears++;
			ACT_READ:  n_reads++;
			default:   n_nops++;
		endcase
		if (n_sent % 64 == 0)
			src_slow = ($urandom_range(0, 3) != 0);
	endtask

	// hold the sender off until every owed result has come back
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		while (sb.owed() != 0) @(posedge clk);
	endtask

	task automatic send_sprite();
		int n;
		int x;
		int y;
		int hot;
		n = $urandom_range(1, 15);
		hot = $urandom_range(0, 1);
		// hot spots sit on the right and bottom edges so that clipping and overlap are common
		x = hot ? $urandom_range(56, 70) : $urandom_range(0, 255);
		y = hot ? $urandom_range(20, 35) : $urandom_range(0, 255);
		for (int i = 0; i < n; i++) begin
			send_cmd(mk_cmd(ACT_DRAW, x, y, i, $urandom_range(0, 255), i == n - 1,
				$urandom_range(0, 31)));
			if ($urandom_range(0, 9) == 0)
				send_cmd(rand_cmd(ACT_READ));
		end
	endtask

	initial begin : sink_side
		int stall;
		res_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = snk_slow ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			sb.check_res(res_if.collision, res_if.done_res, res_if.row_pixels);
			n_results++;
			if (res_if.done_res) begin
				n_done++;
				if (res_if.collision)
					n_collide++;
			end
			if (n_results % 64 == 0)
				snk_slow = ($urandom_range(0, 3) != 0);
		end
	end

	initial begin : source_side
		int pick;
		sb = new();
		arst_n           <= 1'b0;
		cmd_if.valid     <= 1'b0;
		cmd_if.action    <= ACT_NOP;
		cmd_if.x_coord   <= '0;
		cmd_if.y_coord   <= '0;
		cmd_if.row_index <= '0;
		cmd_if.row_byte  <= '0;
		cmd_if.last_row  <= 1'b0;
		cmd_if.read_row  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 0));
		send_cmd(mk_cmd(ACT_DRAW,  0,   0,   0,  'hFF, 0, 0));
		send_cmd(mk_cmd(ACT_DRAW,  0,   0,   1,  'h81, 1, 0));
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 0));
		send_cmd(mk_cmd(ACT_DRAW,  0,   0,   0,  'hFF, 1, 0));   // erases row 0, collision
		send_cmd(mk_cmd(ACT_DRAW,  60,  5,   0,  'hAA, 0, 0));   // clipped at the right edge
		send_cmd(mk_cmd(ACT_DRAW,  255, 5,   1,  'hFF, 1, 0));   // x wraps to the last column
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 5));
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 6));
		send_cmd(mk_cmd(ACT_DRAW,  0,   255, 0,  'h55, 0, 0));   // y wraps to the bottom row
		send_cmd(mk_cmd(ACT_DRAW,  0,   255, 1,  'hFF, 1, 0));   // past the bottom
		send_cmd(mk_cmd(ACT_DRAW,  200, 20,  15, 'hC3, 1, 0));
		send_cmd(mk_cmd(ACT_DRAW,  64,  32,  15, 'hF0, 0, 0));   // no row zero, flag accumulates
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 15));
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 31));
		send_cmd(mk_cmd(ACT_NOP,   255, 255, 15, 'hFF, 1, 31));
		send_cmd(mk_cmd(ACT_DRAW,  0,   31,  0,  'h80, 0, 0));
		send_cmd(mk_cmd(ACT_DRAW,  0,   31,  0,  'h80, 1, 0));   // collision on the bottom row
		send_cmd(mk_cmd(ACT_CLEAR, 255, 255, 15, 'hFF, 1, 31));  // flag survives the clear
		send_cmd(mk_cmd(ACT_READ,  0,   0,   0,  0,    0, 31));
		send_cmd(mk_cmd(ACT_DRAW,  128, 64,  3,  'hFF, 1, 0));
		send_cmd(mk_cmd(ACT_READ,  255, 255, 15, 'hFF, 1, 3));
		send_cmd(mk_cmd(ACT_NOP,   0,   0,   0,  0,    0, 0));
		drain_results();

		// random part, mostly well-formed sprites
		while (n_sent < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_sprite();
			else if (pick < 85)
				send_cmd(rand_cmd(ACT_READ));
			else if (pick < 88) begin
				if ($urandom_range(0, 1) != 0)
					drain_results();
				send_cmd(rand_cmd(ACT_CLEAR));
			end else if (pick < 92)
				send_cmd(rand_cmd(ACT_NOP));
			else
				send_cmd(rand_cmd(ACT_DRAW));
		end

		cmd_if.valid <= 1'b0;
		while (sb.owed() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("run: %0d draws (%0d sprite ends, %0d with collision), %0d reads, %0d clears, %0d idle",
			n_draws, n_done, n_collide, n_reads, n_clears, n_nops);
		$display("run: %0d result items checked, %0d mismatches", n_results, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
